// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== design/ffca_pkg.sv =====
// Package with the shared types and status codes of the allocator.
package ffca_pkg;
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_DIR_FULL  = 2'd1,
		ST_NO_SPACE  = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	localparam logic ACT_CREATE = 1'b0;
	localparam logic ACT_DELETE = 1'b1;

	typedef struct packed {
		logic        action;
		logic [63:0] file_key;
		logic [4:0]  block_count;
	} req_t;

	typedef struct packed {
		status_t    status;
		logic [3:0] start_block;
		logic [4:0] length_done;
	} rsp_t;
endpackage

// ===== design/ffca_if.sv =====
// Valid/ready channel interface carrying a request or a response payload.
interface ffca_req_if import ffca_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ffca_rsp_if import ffca_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/ffca_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module ffca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/ffca_ctrl.sv =====
// Sequencer that scans the free map and the directory and edits both.
module ffca_ctrl import ffca_pkg::*; #(
	parameter int NUM_BLOCKS  = 16,
	parameter int DIR_ENTRIES = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [4:0] blocks_in_use,
	ffca_req_if.sink   req,
	ffca_rsp_if.source rsp,
	output logic                           map_we,
	output logic [$clog2(NUM_BLOCKS)-1:0]  map_waddr,
	output logic                           map_wdata,
	output logic [$clog2(NUM_BLOCKS)-1:0]  map_raddr,
	input  logic                           map_rdata,
	output logic                           dir_we,
	output logic [$clog2(DIR_ENTRIES)-1:0] dir_waddr,
	output logic [64+$clog2(NUM_BLOCKS)+$clog2(NUM_BLOCKS+1)-1:0] dir_wdata,
	output logic [$clog2(DIR_ENTRIES)-1:0] dir_raddr,
	input  logic [64+$clog2(NUM_BLOCKS)+$clog2(NUM_BLOCKS+1)-1:0] dir_rdata
);
	localparam int BW = $clog2(NUM_BLOCKS);
	localparam int DW = $clog2(DIR_ENTRIES);
	localparam int BC = $clog2(NUM_BLOCKS + 1);
	localparam int DC = $clog2(DIR_ENTRIES + 1);
	localparam int SW = (BC > 5) ? BC : 5;
	localparam int EW = 64 + BW + BC;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_INIT  = 8'b00000010,
		S_CSCAN = 8'b00000100,
		S_CMARK = 8'b00001000,
		S_DSCAN = 8'b00010000,
		S_DFREE = 8'b00100000,
		S_SHIFT = 8'b01000000,
		S_RESP  = 8'b10000000
	} state_t;

	state_t      state_q;
	req_t        req_q;
	logic [SW:0] limit_q;
	logic [SW:0] pos_q;
	logic [SW:0] run_start_q;
	logic [SW:0] run_len_q;
	logic        rd_pend_q;
	logic [DC-1:0] count_q;
	logic [DC-1:0] idx_q;
	logic [SW:0] flen_q;
	logic [SW:0] fpos_q;
	rsp_t        rsp_q;
	logic        rvalid_q;
	logic [SW:0] lim_c;
	logic [SW:0] need_c;

	always_comb begin
		lim_c = (SW+1)'(blocks_in_use);
		if (lim_c > (SW+1)'(NUM_BLOCKS)) begin
			lim_c = (SW+1)'(NUM_BLOCKS);
		end
		need_c = (SW+1)'(req_q.block_count);
	end

	assign req.ready = (state_q == S_IDLE) && !rvalid_q;
	assign rsp.valid = rvalid_q;
	assign rsp.data  = rsp_q;

	assign map_raddr = BW'(pos_q);
	assign dir_raddr = DW'(idx_q);

	always_comb begin
		map_we    = 1'b0;
		map_waddr = BW'(fpos_q);
		map_wdata = 1'b0;
		dir_we    = 1'b0;
		dir_waddr = DW'(count_q);
		dir_wdata = {req_q.file_key, BW'(run_start_q), BC'(req_q.block_count)};
		unique case (state_q)
			S_CMARK: begin
				map_we = (flen_q != '0);
				dir_we = (flen_q == '0);
			end
			S_DFREE: begin
				map_we    = (flen_q != '0) && (fpos_q < (SW+1)'(NUM_BLOCKS));
				map_wdata = 1'b1;
			end
			S_SHIFT: begin
				dir_we    = rd_pend_q;
				dir_waddr = DW'(idx_q - DC'(2));
				dir_wdata = dir_rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			rvalid_q <= 1'b0;
			rd_pend_q <= 1'b0;
		end else begin
			if (rvalid_q && rsp.ready) begin
				rvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						req_q   <= req.data;
						limit_q <= lim_c;
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					pos_q <= '0; run_start_q <= '0; run_len_q <= '0;
					idx_q <= '0; rd_pend_q <= 1'b0;
					if (req_q.action == ACT_DELETE) begin
						state_q <= S_DSCAN;
					end else if (count_q >= DC'(DIR_ENTRIES)) begin
						rsp_q <= '{ST_DIR_FULL, 4'd0, 5'd0};
						state_q <= S_RESP;
					end else if (need_c > limit_q) begin
						rsp_q <= '{ST_NO_SPACE, 4'd0, 5'd0};
						state_q <= S_RESP;
					end else if (need_c == '0) begin
						run_start_q <= '0;
						fpos_q <= '0; flen_q <= '0;
						state_q <= S_CMARK;
					end else begin
						state_q <= S_CSCAN;
					end
				end
				S_CSCAN: begin
					if (rd_pend_q) begin
						if (!map_rdata) begin
							run_len_q   <= '0;
							run_start_q <= pos_q;
						end else if (run_len_q + 1'b1 == need_c) begin
							fpos_q <= run_start_q;
							flen_q <= need_c;
							state_q <= S_CMARK;
						end else begin
							run_len_q <= run_len_q + 1'b1;
						end
					end
					if (state_q == S_CSCAN && !(rd_pend_q && map_rdata &&
						run_len_q + 1'b1 == need_c)) begin
						if (pos_q >= limit_q) begin
							rsp_q <= '{ST_NO_SPACE, 4'd0, 5'd0};
							state_q <= S_RESP;
							rd_pend_q <= 1'b0;
						end else begin
							pos_q <= pos_q + 1'b1;
							rd_pend_q <= 1'b1;
						end
					end else begin
						rd_pend_q <= 1'b0;
					end
				end
				S_CMARK: begin
					if (flen_q == '0) begin
						count_q <= count_q + 1'b1;
						rsp_q <= '{ST_OK, 4'(run_start_q), req_q.block_count};
						state_q <= S_RESP;
					end else begin
						fpos_q <= fpos_q + 1'b1;
						flen_q <= flen_q - 1'b1;
					end
				end
				S_DSCAN: begin
					if (rd_pend_q && dir_rdata[EW-1:BW+BC] == req_q.file_key) begin
						fpos_q   <= (SW+1)'(dir_rdata[BW+BC-1:BC]);
						flen_q   <= (SW+1)'(dir_rdata[BC-1:0]);
						rsp_q <= '{ST_OK, 4'(dir_rdata[BW+BC-1:BC]),
							5'(dir_rdata[BC-1:0])};
						rd_pend_q <= 1'b0;
						state_q <= S_DFREE;
					end else if (idx_q >= count_q) begin
						rsp_q <= '{ST_NOT_FOUND, 4'd0, 5'd0};
						rd_pend_q <= 1'b0;
						state_q <= S_RESP;
					end else begin
						idx_q <= idx_q + 1'b1;
						rd_pend_q <= 1'b1;
					end
				end
				S_DFREE: begin
					if (flen_q == '0 || fpos_q >= (SW+1)'(NUM_BLOCKS)) begin
						state_q <= S_SHIFT;
					end else begin
						fpos_q <= fpos_q + 1'b1;
						flen_q <= flen_q - 1'b1;
					end
				end
				S_SHIFT: begin
					if (idx_q >= count_q) begin
						count_q <= count_q - 1'b1;
						rd_pend_q <= 1'b0;
						state_q <= S_RESP;
					end else begin
						idx_q <= idx_q + 1'b1;
						rd_pend_q <= 1'b1;
					end
				end
				S_RESP: begin
					rvalid_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== design/first_fit_contiguous_allocator.sv =====
// A create scans the free map up to blocks_in_use, then marks length blocks; a delete
// scans the directory, frees length blocks and shifts later entries; the scans step one RAM word per cycle.
// One transaction at a time; the next request is taken only once the result has been taken.
// Reset clears the directory count and sets the range register to 16;
// a free-map clearing pass over all NUM_BLOCKS blocks follows, refusing requests.
// Result registered; it is held until taken.
module first_fit_contiguous_allocator import ffca_pkg::*; #(
	parameter int NUM_BLOCKS  = 16,
	parameter int DIR_ENTRIES = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [4:0] cfg_wdata,
	ffca_req_if.sink   req,
	ffca_rsp_if.source rsp
);
	localparam int BW = $clog2(NUM_BLOCKS);
	localparam int DW = $clog2(DIR_ENTRIES);
	localparam int BC = $clog2(NUM_BLOCKS + 1);
	localparam int EW = 64 + BW + BC;

	logic [4:0] blocks_q;
	logic [BW:0] clr_q;
	logic        clr_done;
	logic map_we_c, map_wdata_c, map_rdata, map_we;
	logic [BW-1:0] map_waddr_c, map_raddr, map_waddr;
	logic dir_we;
	logic [DW-1:0] dir_waddr, dir_raddr;
	logic [EW-1:0] dir_wdata, dir_rdata;

	ffca_req_if req_g ();

	assign clr_done = clr_q[BW];
	assign req_g.valid = req.valid && clr_done;
	assign req_g.data  = req.data;
	assign req.ready   = req_g.ready && clr_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocks_q <= 5'd16;
			clr_q    <= '0;
		end else begin
			if (cfg_we) begin
				blocks_q <= cfg_wdata;
			end
			if (!clr_done) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	assign map_we    = clr_done ? map_we_c : 1'b1;
	assign map_waddr = clr_done ? map_waddr_c : BW'(clr_q);

	ffca_ctrl #(.NUM_BLOCKS(NUM_BLOCKS), .DIR_ENTRIES(DIR_ENTRIES)) u_ctrl (
		.clk, .arst_n, .blocks_in_use(blocks_q), .req(req_g), .rsp,
		.map_we(map_we_c), .map_waddr(map_waddr_c), .map_wdata(map_wdata_c),
		.map_raddr, .map_rdata,
		.dir_we, .dir_waddr, .dir_wdata, .dir_raddr, .dir_rdata
	);

	ffca_ram #(.WIDTH(1), .DEPTH(NUM_BLOCKS)) u_map (
		.clk, .we(map_we), .waddr(map_waddr),
		.wdata(clr_done ? map_wdata_c : 1'b1),
		.raddr(map_raddr), .rdata(map_rdata)
	);

	ffca_ram #(.WIDTH(EW), .DEPTH(DIR_ENTRIES)) u_dir (
		.clk, .we(dir_we), .waddr(dir_waddr), .wdata(dir_wdata),
		.raddr(dir_raddr), .rdata(dir_rdata)
	);
endmodule

// ===== design/ffca_checker.sv =====
// Port-level checker for the allocator, bound to the top level.
`include "assert_macros.svh"
module ffca_checker import ffca_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_data
);
	`CHK_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response dropped or changed while stalled")
	`CHK_IMPL(a_err_zero, clk, arst_n, rsp_valid && rsp_data.status != ST_OK, rsp_data.start_block == 4'd0 && rsp_data.length_done == 5'd0, "error result carries nonzero fields")
	`CHK_NEXT(a_one_busy, clk, arst_n, req_valid && req_ready, !req_ready, "second transaction accepted while busy")
	`CHK_IMPL(a_no_overlap, clk, arst_n, rsp_valid, !req_ready, "request taken while a response waits")
endmodule

bind first_fit_contiguous_allocator ffca_checker u_ffca_checker (
	.clk, .arst_n, .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

// ===== tb/sv/tb.sv =====
// Testbench for the first-fit contiguous allocator with a predictor of its results.
`timescale 1ns / 1ps

module tb;
	import ffca_pkg::*;

	localparam int NBLK = 16;
	localparam int NDIR = 16;
	localparam int SETTLE = 60;
	localparam int CYCLE_LIMIT = 1500000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [4:0] cfg_wdata;

	ffca_req_if req_ch ();
	ffca_rsp_if rsp_ch ();

	first_fit_contiguous_allocator #(.NUM_BLOCKS(NBLK), .DIR_ENTRIES(NDIR)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	logic        blk_free [NBLK];
	logic [63:0] dir_key [NDIR];
	logic [3:0]  dir_start [NDIR];
	logic [4:0]  dir_len [NDIR];
	int          dir_count;
	int          range_reg;

	rsp_t pending_rsp [$];
	int errors = 0;
	int cycles = 0;
	int sent;
	int status_seen [4];
	int burst_left;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic rsp_t alloc_predict(req_t r);
		rsp_t o;
		int lim;
		int len;
		int s;
		int b;
		int i;
		bit fits;
		o.status = ST_OK;
		o.start_block = '0;
		o.length_done = '0;
		len = r.block_count;
		if (r.action == ACT_CREATE) begin
			lim = range_reg > NBLK ? NBLK : range_reg;
			if (dir_count >= NDIR) begin
				o.status = ST_DIR_FULL;
				return o;
			end
			if (len > lim) begin
				o.status = ST_NO_SPACE;
				return o;
			end
			for (s = 0; s + len <= lim; s++) begin
				fits = 1'b1;
				for (b = s; b < s + len; b++)
					if (!blk_free[b]) fits = 1'b0;
				if (fits) begin
					for (b = s; b < s + len; b++) blk_free[b] = 1'b0;
					dir_key[dir_count] = r.file_key;
					dir_start[dir_count] = s[3:0];
					dir_len[dir_count] = len[4:0];
					dir_count++;
					o.start_block = s[3:0];
					o.length_done = len[4:0];
					return o;
				end
			end
			o.status = ST_NO_SPACE;
			return o;
		end
		for (i = 0; i < dir_count; i++)
			if (dir_key[i] == r.file_key) break;
		if (i >= dir_count) begin
			o.status = ST_NOT_FOUND;
			return o;
		end
		o.start_block = dir_start[i];
		o.length_done = dir_len[i];
		for (b = dir_start[i]; b < dir_start[i] + dir_len[i] && b < NBLK; b++)
			blk_free[b] = 1'b1;
		for (; i + 1 < dir_count; i++) begin
			dir_key[i] = dir_key[i + 1];
			dir_start[i] = dir_start[i + 1];
			dir_len[i] = dir_len[i + 1];
		end
		dir_count--;
		return o;
	endfunction

	task automatic send_request(input logic act, input logic [63:0] key, input logic [4:0] cnt);
		int gap;
		req_t r;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				req_ch.valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		r.action = act;
		r.file_key = key;
		r.block_count = cnt;
		@(negedge clk);
		req_ch.valid = 1'b1;
		req_ch.data = r;
		do @(posedge clk); while (!req_ch.ready);
		pending_rsp.push_back(alloc_predict(r));
		sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		req_ch.valid = 1'b0;
		burst_left = 0;
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	task automatic write_range(input logic [4:0] v);
		drain();
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		range_reg = v;
	endtask

	int stall_left = 0;
	int stall_mode;
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(5, 60);
		end
		stall_left--;
		case (stall_mode)
			0: rsp_ch.ready = 1'b1;
			1: rsp_ch.ready = 1'($urandom_range(0, 1));
			default: rsp_ch.ready = ($urandom_range(0, 4) == 0);
		endcase
	end

	always @(posedge clk) begin
		rsp_t got;
		rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = rsp_ch.data;
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				want = pending_rsp.pop_front();
				status_seen[want.status]++;
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status,
						got.status);
					errors++;
				end
				if (got.start_block !== want.start_block) begin
					$display("%0t: start_block expected %0d actual %0d", $time,
						want.start_block, got.start_block);
					errors++;
				end
				if (got.length_done !== want.length_done) begin
					$display("%0t: length_done expected %0d actual %0d", $time,
						want.length_done, got.length_done);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		int i;
		send_request(ACT_CREATE, 64'h0, 5'd0);
		send_request(ACT_CREATE, 64'hFFFF_FFFF_FFFF_FFFF, 5'd16);
		send_request(ACT_CREATE, 64'h1, 5'd1);
		send_request(ACT_CREATE, 64'h2, 5'd31);
		send_request(ACT_DELETE, 64'h5555_5555_5555_5555, 5'd31);
		send_request(ACT_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0);
		send_request(ACT_CREATE, 64'hAAAA_AAAA_AAAA_AAAA, 5'd3);
		send_request(ACT_CREATE, 64'hAAAA_AAAA_AAAA_AAAA, 5'd5);
		send_request(ACT_DELETE, 64'hAAAA_AAAA_AAAA_AAAA, 5'd0);
		send_request(ACT_CREATE, 64'h3, 5'd2);
		for (i = 0; i < NDIR; i++)
			send_request(ACT_CREATE, 64'h100 + i, 5'd0);
		send_request(ACT_CREATE, 64'h4, 5'd31);
		drain();
		while (dir_count > 0) send_request(ACT_DELETE, dir_key[dir_count - 1], 5'd0);
	endtask

	task automatic test_range_limits();
		write_range(5'd0);
		send_request(ACT_CREATE, 64'h10, 5'd0);
		send_request(ACT_CREATE, 64'h11, 5'd1);
		send_request(ACT_DELETE, 64'h10, 5'd0);
		write_range(5'd31);
		send_request(ACT_CREATE, 64'h12, 5'd16);
		send_request(ACT_CREATE, 64'h13, 5'd17);
		send_request(ACT_DELETE, 64'h12, 5'd0);
		write_range(5'd16);
		send_request(ACT_CREATE, 64'h14, 5'd4);
		send_request(ACT_CREATE, 64'h15, 5'd8);
		write_range(5'd4);
		send_request(ACT_CREATE, 64'h16, 5'd1);
		send_request(ACT_DELETE, 64'h15, 5'd0);
		send_request(ACT_DELETE, 64'h14, 5'd0);
		send_request(ACT_CREATE, 64'h17, 5'd4);
		send_request(ACT_DELETE, 64'h17, 5'd0);
	endtask

	task automatic test_random(input int n_items);
		int k;
		int lim;
		logic [63:0] key;
		logic [4:0] cnt;
		for (k = 0; k < n_items; k++) begin
			if (k % 200 == 199) begin
				case ($urandom_range(0, 3))
					0: write_range(5'd1);
					1: write_range(5'd16);
					2: write_range(5'($urandom_range(17, 31)));
					default: write_range(5'($urandom_range(0, 15)));
				endcase
			end
			if ($urandom_range(0, 60) == 0) drain();
			lim = range_reg > NBLK ? NBLK : range_reg;
			if ($urandom_range(0, 1) == 0) key = {$urandom, $urandom};
			else key = (64'($urandom_range(0, 7)) << 56) | 64'($urandom_range(0, 7));
			if (dir_count > 0 && $urandom_range(0, 99) < 25 + 4 * dir_count) begin
				if ($urandom_range(0, 9) != 0) key = dir_key[$urandom_range(0, dir_count - 1)];
				send_request(ACT_DELETE, key, 5'($urandom));
			end else begin
				if ($urandom_range(0, 9) == 0) cnt = 5'($urandom);
				else cnt = 5'($urandom_range(0, lim > 6 ? 6 : lim));
				send_request(ACT_CREATE, key, cnt);
			end
		end
	endtask

	initial begin
		int i;
		sent = 0;
		burst_left = 0;
		for (i = 0; i < NBLK; i++) blk_free[i] = 1'b1;
		dir_count = 0;
		range_reg = 16;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_range_limits();
		test_random(1400);
		drain();
		repeat (SETTLE) @(posedge clk);
		$display("Sent %0d requests over several managed ranges, including saturation and zero.",
			sent);
		$display("Results: %0d ok, %0d directory full, %0d no space, %0d not found.",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

// ===== first_fit_contiguous_allocator.f =====
+incdir+design
design/ffca_pkg.sv
design/ffca_if.sv
design/ffca_ram.sv
design/ffca_ctrl.sv
design/first_fit_contiguous_allocator.sv
design/ffca_checker.sv
tb/sv/tb.sv
